// ===== sv/efr_pkg.sv =====
// Package for the escaped frame receiver: codes, state and result types.
package efr_pkg;

  localparam logic [7:0]  START_BYTE       = 8'h7E;
  localparam logic [7:0]  ESCAPE_BYTE      = 8'h7D;
  localparam logic [7:0]  ESCAPE_XOR       = 8'h20;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd900;

  // Verdict codes
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Frame positions with a fixed meaning
  localparam logic [16:0] POS_START  = 17'd0;
  localparam logic [16:0] POS_LEN_HI = 17'd1;
  localparam logic [16:0] POS_LEN_LO = 17'd2;
  localparam logic [16:0] POS_DATA   = 17'd3;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEN_HI   = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CHECKSUM = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        escape_pending;
    logic [15:0] frame_length;
    logic [16:0] position_count;
    logic [7:0]  running_sum;
  } efr_state_t;

  localparam efr_state_t STATE_RESET = '{
    phase:          PH_IDLE,
    escape_pending: 1'b0,
    frame_length:   16'd0,
    position_count: 17'd0,
    running_sum:    8'd0
  };

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [16:0] byte_position;
    logic        last;
    logic [1:0]  status;
  } efr_result_t;

endpackage

// ===== sv/efr_if.sv =====
// Channel interfaces: raw link words in, decoded frame words out, config writes.
interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic [16:0] byte_position;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, output frame_byte, output byte_position,
                  output last, output status, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input last, input status, output ready);
endinterface

interface efr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_length;

  modport source (output valid, output max_length, input ready);
  modport sink   (input valid, input max_length, output ready);
endinterface

// ===== sv/efr_decode.sv =====
// Next-state and result logic for one raw link word.
module efr_decode (
  input  efr_pkg::efr_state_t  st,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          max_length,
  output efr_pkg::efr_state_t  st_next,
  output logic                 emit,
  output efr_pkg::efr_result_t res
);
  import efr_pkg::*;

  logic [7:0]  d;
  logic [15:0] len_full;
  logic [16:0] pos_inc;
  logic [16:0] pos_end;
  logic [7:0]  total;

  assign d        = st.escape_pending ? (rx_byte ^ ESCAPE_XOR) : rx_byte;
  assign len_full = {st.frame_length[15:8], d};
  assign pos_inc  = st.position_count + 17'd1;
  assign pos_end  = {1'b0, st.frame_length} + POS_DATA;
  assign total    = st.running_sum + d + 8'd1;

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    res     = '{frame_byte: d, byte_position: st.position_count,
                last: 1'b0, status: ST_GOOD};

    if (rx_byte == START_BYTE) begin
      // restart always wins, even after an escape
      st_next          = STATE_RESET;
      st_next.phase    = PH_LEN_HI;
      st_next.position_count = POS_LEN_HI;
      emit             = 1'b1;
      res.frame_byte   = rx_byte;
      res.byte_position = POS_START;
    end else if (st.phase == PH_IDLE) begin
      st_next.escape_pending = 1'b0;
    end else if (!st.escape_pending && rx_byte == ESCAPE_BYTE) begin
      st_next.escape_pending = 1'b1;
    end else begin
      st_next.escape_pending = 1'b0;
      unique case (st.phase)
        PH_LEN_HI: begin
          st_next.frame_length   = {d, 8'h00};
          st_next.position_count = POS_LEN_LO;
          st_next.phase          = PH_LEN_LO;
          emit                   = 1'b1;
          res.byte_position      = POS_LEN_HI;
        end
        PH_LEN_LO: begin
          st_next.frame_length = len_full;
          emit                 = 1'b1;
          res.byte_position    = POS_LEN_LO;
          if (len_full > max_length) begin
            st_next.phase = PH_IDLE;
            res.last      = 1'b1;
            res.status    = ST_TOO_LONG;
          end else begin
            st_next.position_count = POS_DATA;
            st_next.phase          = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          st_next.running_sum    = st.running_sum + d;
          st_next.position_count = pos_inc;
          if (pos_inc >= pos_end) st_next.phase = PH_CHECKSUM;
          emit = 1'b1;
        end
        PH_CHECKSUM: begin
          st_next.phase = PH_IDLE;
          emit          = 1'b1;
          res.last      = 1'b1;
          res.status    = (total == 8'd0) ? ST_GOOD : ST_BAD;
        end
        default: begin
          st_next.phase          = PH_IDLE;
          st_next.escape_pending = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/escaped_frame_receiver.sv =====
// Escaped frame receiver: raw link words in, decoded frame words and verdicts out.
// A taken word is held in the input register, decoded, and its result written to the output register.
// Throughput: one raw word per cycle while the output is not stalled, set by the single
//   decode pass between the input register and the output register.
// Escape words and stray words outside a frame give no output word.
// Reset (rst, synchronous): receiver idle, both registers empty, max_length = 900.
module escaped_frame_receiver (
  input logic       clk,
  input logic       rst,
  efr_cfg_if.sink   cfg,
  efr_in_if.sink    rx,
  efr_out_if.source frame
);
  import efr_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // frame state and config
  efr_state_t  st;
  efr_state_t  st_next;
  logic [15:0] max_length;

  // output register
  logic        out_valid;
  efr_result_t out_res;

  logic        emit;
  efr_result_t res;
  logic        advance;

  // output slot free or draining this cycle
  assign advance  = !out_valid || frame.ready;
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  efr_decode u_decode (
    .st         (st),
    .rx_byte    (in_byte),
    .max_length (max_length),
    .st_next    (st_next),
    .emit       (emit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      st         <= STATE_RESET;
      max_length <= MAX_LENGTH_RESET;
    end else begin
      if (cfg.valid && cfg.ready) max_length <= cfg.max_length;
      if (rx.ready) in_valid <= rx.valid;
      // state moves only when the held word is consumed
      if (in_valid && advance) st <= st_next;
      if (advance) out_valid <= in_valid && emit;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (rx.ready) in_byte <= rx.rx_byte;
    if (advance && in_valid && emit) out_res <= res;
  end

  assign frame.valid         = out_valid;
  assign frame.frame_byte    = out_res.frame_byte;
  assign frame.byte_position = out_res.byte_position;
  assign frame.last          = out_res.last;
  assign frame.status        = out_res.status;

endmodule

// ===== sv/efr_checker.sv =====
// Port-level checks for the escaped frame receiver, bound to the top level.
module efr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  frame_byte,
  input logic [16:0] byte_position,
  input logic        last,
  input logic [1:0]  status
);
  import efr_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) &&
      $stable(byte_position) && $stable(last) && $stable(status))
    else $error("output word changed while stalled");

  // a start word is the raw start byte and never a verdict
  a_start_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_position == POS_START |-> frame_byte == START_BYTE && !last)
    else $error("bad start word");

  // data words carry no status; verdicts carry a defined one
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last ? (status == ST_GOOD || status == ST_BAD ||
      status == ST_TOO_LONG) : status == ST_GOOD))
    else $error("status on wrong word");

  // length verdict sits at the length low byte, checksum verdict at any other position
  a_verdict_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (status == ST_TOO_LONG) == (byte_position == POS_LEN_LO))
    else $error("verdict at wrong position");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (frame.valid),
  .out_ready     (frame.ready),
  .frame_byte    (frame.frame_byte),
  .byte_position (frame.byte_position),
  .last          (frame.last),
  .status        (frame.status)
);

// ===== bench/escaped_frame_receiver_test.sv =====
// Self-checking testbench for the escaped frame receiver: directed frames, limits, random traffic.
`timescale 1ns / 100ps

module escaped_frame_receiver_test;
  import efr_pkg::*;

  localparam int STALL_LIMIT = 2000; // cycles with no word moving on any channel
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off for the fill-up test
  localparam int DRAIN_PAUSE = 8;    // quiet cycles after the last expected word

  logic clk;
  logic rst;

  efr_cfg_if cfg_ch ();
  efr_in_if  rx_ch ();
  efr_out_if frame_ch ();

  escaped_frame_receiver uut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .rx    (rx_ch),
    .frame (frame_ch)
  );

  // Handshake pacing, changed per phase.
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  bit hold_req      = 1'b0;

  // Decoder copy: state and register as the block should hold them.
  phase_t      dec_phase    = PH_IDLE;
  logic        dec_escape   = 1'b0;
  logic [15:0] dec_length   = '0;
  logic [16:0] dec_position = '0;
  logic [7:0]  dec_sum      = '0;
  logic [15:0] max_len_cfg  = MAX_LENGTH_RESET;

  efr_result_t expected_words[$];
  int          words_predicted = 0;
  int          mismatch_count  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Expected-word bookkeeping
  // ---------------------------------------------------------------------------
  function automatic void expect_word(logic [7:0] b, logic [16:0] p, logic l, logic [1:0] s);
    expected_words.push_back('{frame_byte: b, byte_position: p, last: l, status: s});
    words_predicted++;
  endfunction

  // Decode one accepted raw word against the copy of the state.
  function automatic void decode_raw_word(logic [7:0] raw);
    logic [7:0]  c;
    logic [16:0] pos;
    logic [7:0]  total;
    c = raw;
    // A raw start word always wins, even right after an escape.
    if (c == START_BYTE) begin
      dec_phase    = PH_LEN_HI;
      dec_escape   = 1'b0;
      dec_length   = '0;
      dec_position = POS_LEN_HI;
      dec_sum      = '0;
      expect_word(c, POS_START, 1'b0, ST_GOOD);
      return;
    end
    // Outside a frame everything is dropped, escapes included.
    if (dec_phase == PH_IDLE) begin
      dec_escape = 1'b0;
      return;
    end
    if (!dec_escape && c == ESCAPE_BYTE) begin
      dec_escape = 1'b1;
      return;
    end
    if (dec_escape) begin
      c          = c ^ ESCAPE_XOR;
      dec_escape = 1'b0;
    end
    case (dec_phase)
      PH_LEN_HI: begin
        dec_length   = {c, 8'h00};
        dec_position = POS_LEN_LO;
        dec_phase    = PH_LEN_LO;
        expect_word(c, POS_LEN_HI, 1'b0, ST_GOOD);
      end
      PH_LEN_LO: begin
        dec_length = {dec_length[15:8], c};
        if (dec_length > max_len_cfg) begin
          dec_phase = PH_IDLE;
          expect_word(c, POS_LEN_LO, 1'b1, ST_TOO_LONG);
        end else begin
          dec_position = POS_DATA;
          dec_phase    = PH_PAYLOAD;
          expect_word(c, POS_LEN_LO, 1'b0, ST_GOOD);
        end
      end
      PH_PAYLOAD: begin
        pos          = dec_position;
        dec_sum      = dec_sum + c;
        dec_position = dec_position + 17'd1;
        // at least one payload word, even for a zero length
        if (32'(dec_position) >= 32'(dec_length) + 32'd3) dec_phase = PH_CHECKSUM;
        expect_word(c, pos, 1'b0, ST_GOOD);
      end
      default: begin
        total     = dec_sum + c + 8'd1;
        dec_phase = PH_IDLE;
        expect_word(c, dec_position, 1'b1, (total == 8'd0) ? ST_GOOD : ST_BAD);
      end
    endcase
  endfunction

  function automatic void check_frame_word();
    efr_result_t got;
    efr_result_t want;
    got = '{frame_byte: frame_ch.frame_byte, byte_position: frame_ch.byte_position,
            last: frame_ch.last, status: frame_ch.status};
    if (expected_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected frame word: byte %h pos %0d last %b status %0d",
                 got.frame_byte, got.byte_position, got.last, got.status);
      return;
    end
    want = expected_words.pop_front();
    if (got.frame_byte !== want.frame_byte || got.byte_position !== want.byte_position ||
        got.last !== want.last || got.status !== want.status) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display({"frame word mismatch: expected byte %h pos %0d last %b status %0d,",
                  " got byte %h pos %0d last %b status %0d"},
                 want.frame_byte, want.byte_position, want.last, want.status,
                 got.frame_byte, got.byte_position, got.last, got.status);
    end
  endfunction

  // Config, input and output words are all sampled at the same edge, in one
  // process, so the register copy and queue order never race.
  always @(posedge clk) begin
    if (rst) begin
      dec_phase    = PH_IDLE;
      dec_escape   = 1'b0;
      dec_length   = '0;
      dec_position = '0;
      dec_sum      = '0;
      max_len_cfg  = MAX_LENGTH_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) max_len_cfg = cfg_ch.max_length;
      if (rx_ch.valid && rx_ch.ready) decode_raw_word(rx_ch.rx_byte);
      if (frame_ch.valid && frame_ch.ready) check_frame_word();
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run if no word moves for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one raw word, after a random idle gap; returns at the accepting edge
  // with valid still high, so back-to-back words need no extra assignment.
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  // Send a frame word, escaped when it must be and now and then when it need not.
  // 0x5E is never escaped by choice: escaped it would read as a raw start word.
  task automatic send_escaped(input logic [7:0] v);
    if (v == START_BYTE || v == ESCAPE_BYTE ||
        (v != (START_BYTE ^ ESCAPE_XOR) && $urandom_range(7) == 0)) begin
      send_word(ESCAPE_BYTE);
      send_word(v ^ ESCAPE_XOR);
    end else begin
      send_word(v);
    end
  endtask

  // Whole frame with random payload. stop_at >= 0 cuts the frame after that many
  // frame words. An oversize length is followed only by a few stray words.
  task automatic send_frame(input int len, input bit ok_sum, input int stop_at);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] v;
    int n;
    sum = '0;
    body.push_back(len[15:8]);
    body.push_back(len[7:0]);
    if (len > max_len_cfg) n = $urandom_range(3);
    else n = (len == 0) ? 1 : len;
    for (int i = 0; i < n; i++) begin
      v = 8'($urandom);
      body.push_back(v);
      sum = sum + v;
    end
    if (len <= max_len_cfg) body.push_back(ok_sum ? ~sum : (~sum ^ 8'($urandom_range(255, 1))));
    send_word(START_BYTE);
    foreach (body[i]) begin
      if (i == stop_at) return;
      send_escaped(body[i]);
    end
  endtask

  // Stop offering, let every expected word arrive, then give the block a few
  // quiet cycles so the pipeline is empty before a register write.
  task automatic wait_until_drained();
    rx_ch.valid <= 1'b0;
    // wait so the last accepted word is already in the queue
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    wait_until_drained();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.max_length <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    // let the register copy settle before the next frame is built from it
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_frames();
    snd_idle_pct  = 20;
    rcv_stall_pct = 20;
    // zero length still carries one payload word; sum FF needs checksum 00
    send_word(START_BYTE); send_word(8'h00); send_word(8'h00);
    send_word(8'hFF); send_word(8'h00);
    // escaped start value as payload, checksum wrong
    send_word(START_BYTE); send_word(8'h00); send_word(8'h01);
    send_word(ESCAPE_BYTE); send_word(START_BYTE ^ ESCAPE_XOR); send_word(8'h00);
    // largest length, dropped at the low length word
    send_word(START_BYTE); send_word(8'hFF); send_word(8'hFF);
    // one past the reset limit of 900
    send_word(START_BYTE); send_word(8'h03); send_word(8'h85);
  endtask

  task automatic test_stray_and_restart();
    snd_idle_pct  = 20;
    rcv_stall_pct = 20;
    // idle: plain and escaped strays give nothing
    send_word(8'h00); send_word(8'hFF); send_word(ESCAPE_BYTE); send_word(8'h20);
    // restart in the payload, right after an escape
    send_word(START_BYTE); send_word(8'h00); send_word(8'h02); send_word(8'h11);
    send_word(ESCAPE_BYTE); send_word(START_BYTE);
    // fresh frame: a doubled escape is data 5D; 5D + 80 = DD, checksum 22
    send_word(8'h00); send_word(8'h02); send_word(ESCAPE_BYTE); send_word(ESCAPE_BYTE);
    send_word(8'h80); send_word(8'h22);
  endtask

  task automatic test_length_limits();
    // limit 0: only zero-length frames pass
    write_max_length(16'd0);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_frame(0, 1'b1, -1);
    send_frame(1, 1'b1, -1);
    // full limit: the largest length is taken, then the frame is cut short
    write_max_length(16'hFFFF);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_frame(65535, 1'b1, 5);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills up and pushes back on its input.
  task automatic test_backpressure();
    write_max_length(MAX_LENGTH_RESET);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req <= 1'b1;
    repeat (3) send_frame(20, 1'b1, -1);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                     input logic [15:0] limit, input int n_words);
    int goal;
    int r;
    int cap;
    int len;
    int over;
    int room;
    write_max_length(limit);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    goal = words_predicted + n_words;
    while (words_predicted < goal) begin
      r   = $urandom_range(99);
      cap = ($urandom_range(9) == 0) ? 60 : 12;
      if (cap > max_len_cfg) cap = max_len_cfg;
      len = $urandom_range(cap);
      room = 65534 - int'(max_len_cfg);
      over = int'(max_len_cfg) + 1 + $urandom_range((room < 300) ? room : 300);
      if ($urandom_range(3) == 0) over = 65535;
      if (r < 70) begin
        send_frame(len, $urandom_range(4) != 0, -1);
      end else if (r < 80 && max_len_cfg != 16'hFFFF) begin
        send_frame(over, 1'b1, -1);
      end else if (r < 90) begin
        // cut short; whatever follows lands inside the broken frame
        send_frame(len, 1'b1, $urandom_range(len + 2));
      end else begin
        repeat ($urandom_range(6, 1)) send_word(8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               <= 1'b1;
    rx_ch.valid       <= 1'b0;
    rx_ch.rx_byte     <= 8'h00;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.max_length <= MAX_LENGTH_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_stray_and_restart();
    test_length_limits();
    test_backpressure();
    test_random_traffic(0, 0, MAX_LENGTH_RESET, 380);
    test_random_traffic(83, 0, 16'd0, 380);
    test_random_traffic(0, 83, 16'hFFFF, 380);
    test_random_traffic(20, 20, 16'd17, 380);

    wait_until_drained();
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
